/* design/owbm_pkg.sv */
// Shared types and constants of the single-wire bus master.
`timescale 1ns / 1ps
`default_nettype none
package owbm_pkg;

  localparam int REG_IDX_W = 3;

  typedef logic [1:0] req_code_t;
  localparam req_code_t REQ_TICK  = 2'd0;
  localparam req_code_t REQ_RESET = 2'd1;
  localparam req_code_t REQ_WRITE = 2'd2;
  localparam req_code_t REQ_READ  = 2'd3;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_RESET_PRE  = 3'd0;
  localparam reg_idx_t REG_RESET_LOW  = 3'd1;
  localparam reg_idx_t REG_PRES_WAIT  = 3'd2;
  localparam reg_idx_t REG_RESET_TAIL = 3'd3;
  localparam reg_idx_t REG_WRITE_SLOT = 3'd4;
  localparam reg_idx_t REG_WRITE_TAIL = 3'd5;
  localparam reg_idx_t REG_READ_PRE   = 3'd6;
  localparam reg_idx_t REG_READ_TAIL  = 3'd7;

  typedef struct packed {
    req_code_t  req_type;
    logic [7:0] write_byte;
    logic       line_in;
  } word_t;

endpackage
`default_nettype wire

/* design/owbm_in_reg.sv */
// Input register stage that holds one accepted word for the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module owbm_in_reg
  import owbm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire req_code_t  req_type,
  input  wire logic [7:0] write_byte,
  input  wire logic       line_in,
  input  wire logic       take,
  output logic            held_valid,
  output word_t           held_word
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      held_word <= '{req_type: req_type, write_byte: write_byte, line_in: line_in};
    end
  end

endmodule
`default_nettype wire

/* design/owbm_seq.sv */
// Bus sequencer: timing registers, phase machine and result register.
`timescale 1ns / 1ps
`default_nettype none
module owbm_seq
  import owbm_pkg::*;
#(
  parameter int TIMER_WIDTH = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire reg_idx_t               cfg_index,
  input  wire logic [TIMER_WIDTH-1:0] cfg_data,
  input  wire logic                   held_valid,
  input  wire word_t                  held_word,
  output logic                        take,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        drive_low,
  output logic                        busy_res,
  output logic                        done_res,
  output logic [7:0]                  read_byte,
  output logic                        presence
);

  localparam int NUM_REGS = 1 << REG_IDX_W;

  typedef enum logic [3:0] {
    PH_IDLE, PH_R_PRE, PH_R_LOW, PH_R_WAIT, PH_R_SAMPLE, PH_R_TAIL,
    PH_W_PULSE, PH_W_SLOT, PH_W_TAIL, PH_RD_PRE, PH_RD_PULSE,
    PH_RD_SAMPLE, PH_RD_TAIL
  } phase_t;

  logic [TIMER_WIDTH-1:0] timing [NUM_REGS];
  phase_t                 phase, phase_next;
  logic [TIMER_WIDTH-1:0] tick_count, tick_count_next;
  logic [2:0]             bit_count, bit_count_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic                   presence_flag, presence_flag_next;
  logic [7:0]             last_read, last_read_next;
  logic                   drive, done;
  logic [TIMER_WIDTH-1:0] lim;
  logic [TIMER_WIDTH:0]   tick_inc;
  logic                   hit;
  logic [TIMER_WIDTH-1:0] tick_step;

  function automatic logic phase_drive(phase_t p, logic b0);
    logic d;
    case (p)
      PH_R_LOW, PH_W_PULSE, PH_RD_PULSE: d = 1'b1;
      PH_W_SLOT: d = !b0;
      default: d = 1'b0;
    endcase
    return d;
  endfunction

  assign cfg_ready = 1'b1;
  assign take = held_valid && (!out_valid || out_ready);

  always_comb begin
    case (phase)
      PH_R_PRE:  lim = timing[REG_RESET_PRE];
      PH_R_LOW:  lim = timing[REG_RESET_LOW];
      PH_R_WAIT: lim = timing[REG_PRES_WAIT];
      PH_R_TAIL: lim = timing[REG_RESET_TAIL];
      PH_W_SLOT: lim = timing[REG_WRITE_SLOT];
      PH_W_TAIL: lim = timing[REG_WRITE_TAIL];
      PH_RD_PRE: lim = timing[REG_READ_PRE];
      default:   lim = timing[REG_READ_TAIL];
    endcase
  end

  // A limit of zero ends the phase after one tick, like a limit of one.
  assign tick_inc  = (TIMER_WIDTH+1)'(tick_count) + (TIMER_WIDTH+1)'(1);
  assign hit       = tick_inc >= (TIMER_WIDTH+1)'(lim);
  assign tick_step = hit ? '0 : tick_inc[TIMER_WIDTH-1:0];

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_count_next     = bit_count;
    shift_byte_next    = shift_byte;
    presence_flag_next = presence_flag;
    last_read_next     = last_read;
    done               = 1'b0;
    if (held_word.req_type != REQ_TICK) begin
      if (phase == PH_IDLE) begin
        tick_count_next = '0;
        bit_count_next  = '0;
        case (held_word.req_type)
          REQ_RESET: phase_next = PH_R_PRE;
          REQ_WRITE: begin
            shift_byte_next = held_word.write_byte;
            phase_next      = PH_W_PULSE;
          end
          default: begin
            shift_byte_next = '0;
            phase_next      = PH_RD_PRE;
          end
        endcase
      end
      drive = phase_drive(phase_next, shift_byte_next[0]);
    end else begin
      drive = phase_drive(phase, shift_byte[0]);
      case (phase)
        PH_R_PRE: begin
          tick_count_next = tick_step;
          if (hit) phase_next = PH_R_LOW;
        end
        PH_R_LOW: begin
          tick_count_next = tick_step;
          if (hit) phase_next = PH_R_WAIT;
        end
        PH_R_WAIT: begin
          tick_count_next = tick_step;
          if (hit) phase_next = PH_R_SAMPLE;
        end
        PH_R_SAMPLE: begin
          presence_flag_next = !held_word.line_in;
          tick_count_next    = '0;
          phase_next         = PH_R_TAIL;
        end
        PH_R_TAIL: begin
          tick_count_next = tick_step;
          if (hit) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
        end
        PH_W_PULSE: begin
          tick_count_next = '0;
          phase_next      = PH_W_SLOT;
        end
        PH_W_SLOT: begin
          tick_count_next = tick_step;
          if (hit) begin
            shift_byte_next = {1'b0, shift_byte[7:1]};
            bit_count_next  = bit_count + 3'd1;
            phase_next      = (bit_count == 3'd7) ? PH_W_TAIL : PH_W_PULSE;
          end
        end
        PH_W_TAIL: begin
          tick_count_next = tick_step;
          if (hit) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
        end
        PH_RD_PRE: begin
          tick_count_next = tick_step;
          if (hit) phase_next = PH_RD_PULSE;
        end
        PH_RD_PULSE: phase_next = PH_RD_SAMPLE;
        PH_RD_SAMPLE: begin
          shift_byte_next = {held_word.line_in, shift_byte[7:1]};
          tick_count_next = '0;
          phase_next      = PH_RD_TAIL;
        end
        PH_RD_TAIL: begin
          tick_count_next = tick_step;
          if (hit) begin
            bit_count_next = bit_count + 3'd1;
            if (bit_count == 3'd7) begin
              last_read_next = shift_byte;
              phase_next     = PH_IDLE;
              done           = 1'b1;
            end else begin
              phase_next = PH_RD_PRE;
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timing[REG_RESET_PRE]  <= TIMER_WIDTH'(72);
      timing[REG_RESET_LOW]  <= TIMER_WIDTH'(720);
      timing[REG_PRES_WAIT]  <= TIMER_WIDTH'(45);
      timing[REG_RESET_TAIL] <= TIMER_WIDTH'(180);
      timing[REG_WRITE_SLOT] <= TIMER_WIDTH'(45);
      timing[REG_WRITE_TAIL] <= TIMER_WIDTH'(36);
      timing[REG_READ_PRE]   <= TIMER_WIDTH'(9);
      timing[REG_READ_TAIL]  <= TIMER_WIDTH'(36);
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_count     <= '0;
      shift_byte    <= '0;
      presence_flag <= 1'b0;
      last_read     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        timing[cfg_index] <= cfg_data;
      end
      if (take) begin
        phase         <= phase_next;
        tick_count    <= tick_count_next;
        bit_count     <= bit_count_next;
        shift_byte    <= shift_byte_next;
        presence_flag <= presence_flag_next;
        last_read     <= last_read_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (take) begin
      drive_low <= drive;
      busy_res  <= phase_next != PH_IDLE;
      done_res  <= done;
      read_byte <= last_read_next;
      presence  <= presence_flag_next;
    end
  end

endmodule
`default_nettype wire

/* design/one_wire_bus_master.sv */
// Top level of the single-wire bus master.
// The block takes one word per clock cycle while the output side does not stall and gives one result word for each.
// A word passes an input register and then the sequencer, which advances the
// bus phase by one step and loads the result register. Tick words each stand
// for one microsecond of bus time; command words start a reset, write or read
// sequence when the master is idle and are otherwise ignored. Timing registers
// are written through the configuration channel, which is always ready, and
// must be written only while the master is idle.
`timescale 1ns / 1ps
`default_nettype none
module one_wire_bus_master
  import owbm_pkg::*;
#(
  parameter int TIMER_WIDTH = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire reg_idx_t               cfg_index,
  input  wire logic [TIMER_WIDTH-1:0] cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire req_code_t              req_type,
  input  wire logic [7:0]             write_byte,
  input  wire logic                   line_in,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        drive_low,
  output logic                        busy_res,
  output logic                        done_res,
  output logic [7:0]                  read_byte,
  output logic                        presence
);

  logic  held_valid;
  word_t held_word;
  logic  take;

  owbm_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .write_byte (write_byte),
    .line_in    (line_in),
    .take       (take),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  owbm_seq #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .held_valid (held_valid),
    .held_word  (held_word),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .drive_low  (drive_low),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .read_byte  (read_byte),
    .presence   (presence)
  );

endmodule
`default_nettype wire

/* design/owbm_checker.sv */
// Port checker of the single-wire bus master and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module owbm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       drive_low,
  input wire logic       busy_res,
  input wire logic       done_res,
  input wire logic [7:0] read_byte,
  input wire logic       presence
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive_low) && $stable(busy_res)
      && $stable(done_res) && $stable(read_byte) && $stable(presence))
    else $error("stalled result word changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("sequence finished but still busy");

  // Every sequence ends in a released phase, so an idle result never drives.
  a_idle_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> !drive_low)
    else $error("line driven low while idle");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .drive_low (drive_low),
  .busy_res  (busy_res),
  .done_res  (done_res),
  .read_byte (read_byte),
  .presence  (presence)
);
`default_nettype wire

/* bench/tb_one_wire_bus_master.sv */
// Self-checking testbench for the single-wire bus master: directed and random words.
`timescale 1ns / 1ps
module tb_one_wire_bus_master;
  import owbm_pkg::*;

  localparam int TW          = 10;
  localparam int CYCLE_LIMIT = 6_000_000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RST_PRE, ST_RST_LOW, ST_RST_WAIT, ST_RST_SAMPLE, ST_RST_TAIL,
    ST_WR_PULSE, ST_WR_SLOT, ST_WR_TAIL,
    ST_RD_PRE, ST_RD_PULSE, ST_RD_SAMPLE, ST_RD_TAIL
  } bus_phase_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       presence;
  } bus_status_t;

  typedef struct packed {
    req_code_t   req;
    logic [7:0]  wbyte;
    logic        line;
    int          reps;
    bit          fixed;
    bus_status_t want;
  } stim_row_t;

  localparam bus_status_t ST_ZERO = '{1'b0, 1'b0, 1'b0, 8'h00, 1'b0};
  localparam bus_status_t ST_BUSY = '{1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
  localparam int DEFAULT_ROWS = 5;
  localparam int SCRIPT_ROWS  = 23;

  localparam stim_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{REQ_TICK,  8'hFF, 1'b1, 1,  1'b1, ST_ZERO},
    '{REQ_TICK,  8'h00, 1'b0, 1,  1'b1, ST_ZERO},
    '{REQ_RESET, 8'hA5, 1'b1, 1,  1'b1, ST_BUSY},
    '{REQ_WRITE, 8'h3C, 1'b0, 1,  1'b1, ST_BUSY},
    '{REQ_READ,  8'hC3, 1'b1, 1,  1'b1, ST_BUSY},
    '{REQ_WRITE, 8'hFF, 1'b1, 1,  1'b0, ST_ZERO},
    '{REQ_TICK,  8'h00, 1'b1, 20, 1'b0, ST_ZERO},
    '{REQ_WRITE, 8'h00, 1'b0, 1,  1'b0, ST_ZERO},
    '{REQ_TICK,  8'hFF, 1'b0, 20, 1'b0, ST_ZERO},
    '{REQ_READ,  8'h00, 1'b1, 1,  1'b0, ST_ZERO},
    '{REQ_TICK,  8'h00, 1'b1, 34, 1'b0, ST_ZERO},
    '{REQ_READ,  8'hFF, 1'b0, 1,  1'b0, ST_ZERO},
    '{REQ_TICK,  8'hFF, 1'b0, 34, 1'b0, ST_ZERO},
    '{REQ_RESET, 8'h00, 1'b1, 1,  1'b0, ST_ZERO},
    '{REQ_TICK,  8'h00, 1'b1, 6,  1'b0, ST_ZERO},
    '{REQ_RESET, 8'hFF, 1'b0, 1,  1'b0, ST_ZERO},
    '{REQ_TICK,  8'h00, 1'b0, 6,  1'b0, ST_ZERO},
    '{REQ_READ,  8'h5A, 1'b1, 1,  1'b0, ST_ZERO},
    '{REQ_TICK,  8'h00, 1'b1, 3,  1'b0, ST_ZERO},
    '{REQ_WRITE, 8'h81, 1'b0, 1,  1'b0, ST_ZERO},
    '{REQ_RESET, 8'h7E, 1'b1, 1,  1'b0, ST_ZERO},
    '{REQ_TICK,  8'h00, 1'b0, 31, 1'b0, ST_ZERO},
    '{REQ_TICK,  8'hFF, 1'b0, 2,  1'b0, ST_ZERO}
  };

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  reg_idx_t       cfg_index = '0;
  logic [TW-1:0]  cfg_data = '0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  req_code_t      req_type = REQ_TICK;
  logic [7:0]     write_byte = 8'h00;
  logic           line_in = 1'b1;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic           drive_low;
  logic           busy_res;
  logic           done_res;
  logic [7:0]     read_byte;
  logic           presence;

  bus_phase_t     ph = ST_IDLE;
  logic [TW-1:0]  tcount = '0;
  logic [2:0]     bcount = '0;
  logic [7:0]     sreg = 8'h00;
  logic           pres_flag = 1'b0;
  logic [7:0]     last_rd = 8'h00;
  logic [TW-1:0]  timing [8] = '{10'd72, 10'd720, 10'd45, 10'd180,
                                 10'd45, 10'd36, 10'd9, 10'd36};
  logic [TW-1:0]  plan [8];

  bus_status_t    status_q [$];
  int             err_count = 0;
  int             cycle_count = 0;
  int             out_hold = 0;
  bit             in_calm = 1'b0;
  bit             out_calm = 1'b0;

  one_wire_bus_master #(.TIMER_WIDTH(TW)) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .write_byte (write_byte),
    .line_in    (line_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .drive_low  (drive_low),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .read_byte  (read_byte),
    .presence   (presence)
  );

  always #5 clk = ~clk;

  function automatic logic line_drive();
    case (ph)
      ST_RST_LOW, ST_WR_PULSE, ST_RD_PULSE: return 1'b1;
      ST_WR_SLOT: return ~sreg[0];
      default: return 1'b0;
    endcase
  endfunction

  // A timed phase ends on the tick that brings the count up to its register.
  function automatic logic timer_done(reg_idx_t idx);
    if (32'(tcount) + 32'd1 >= 32'(timing[idx])) begin
      tcount = '0;
      return 1'b1;
    end
    tcount = tcount + 1'b1;
    return 1'b0;
  endfunction

  function automatic bus_status_t step_bus(req_code_t r, logic [7:0] b, logic l);
    bus_status_t s;
    logic done;
    done = 1'b0;
    if (r != REQ_TICK) begin
      if (ph == ST_IDLE) begin
        tcount = '0;
        bcount = '0;
        case (r)
          REQ_RESET: ph = ST_RST_PRE;
          REQ_WRITE: begin
            sreg = b;
            ph = ST_WR_PULSE;
          end
          default: begin
            sreg = 8'h00;
            ph = ST_RD_PRE;
          end
        endcase
      end
      s.drive_low = line_drive();
    end else begin
      s.drive_low = line_drive();
      case (ph)
        ST_RST_PRE:  if (timer_done(REG_RESET_PRE)) ph = ST_RST_LOW;
        ST_RST_LOW:  if (timer_done(REG_RESET_LOW)) ph = ST_RST_WAIT;
        ST_RST_WAIT: if (timer_done(REG_PRES_WAIT)) ph = ST_RST_SAMPLE;
        ST_RST_SAMPLE: begin
          pres_flag = ~l;
          tcount = '0;
          ph = ST_RST_TAIL;
        end
        ST_RST_TAIL: if (timer_done(REG_RESET_TAIL)) begin
          ph = ST_IDLE;
          done = 1'b1;
        end
        ST_WR_PULSE: begin
          tcount = '0;
          ph = ST_WR_SLOT;
        end
        ST_WR_SLOT: if (timer_done(REG_WRITE_SLOT)) begin
          sreg = sreg >> 1;
          if (bcount == 3'd7) begin
            bcount = '0;
            ph = ST_WR_TAIL;
          end else begin
            bcount = bcount + 1'b1;
            ph = ST_WR_PULSE;
          end
        end
        ST_WR_TAIL: if (timer_done(REG_WRITE_TAIL)) begin
          ph = ST_IDLE;
          done = 1'b1;
        end
        ST_RD_PRE:   if (timer_done(REG_READ_PRE)) ph = ST_RD_PULSE;
        ST_RD_PULSE: ph = ST_RD_SAMPLE;
        ST_RD_SAMPLE: begin
          sreg = {l, sreg[7:1]};
          tcount = '0;
          ph = ST_RD_TAIL;
        end
        ST_RD_TAIL: if (timer_done(REG_READ_TAIL)) begin
          if (bcount == 3'd7) begin
            bcount = '0;
            last_rd = sreg;
            ph = ST_IDLE;
            done = 1'b1;
          end else begin
            bcount = bcount + 1'b1;
            ph = ST_RD_PRE;
          end
        end
        default: ph = ST_IDLE;
      endcase
    end
    s.busy_res = (ph != ST_IDLE);
    s.done_res = done;
    s.read_byte = last_rd;
    s.presence = pres_flag;
    return s;
  endfunction

  function automatic int gap_len(bit calm);
    int r;
    r = $urandom_range(99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endfunction

  // Called at the edge that accepted the previous word, so valid only drops for a gap.
  task automatic send_word(req_code_t r, logic [7:0] b, logic l, bit fixed,
                           bus_status_t want);
    int gap;
    bus_status_t s;
    gap = gap_len(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r;
    write_byte <= b;
    line_in <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    s = step_bus(r, b, l);
    status_q.push_back(fixed ? want : s);
  endtask

  task automatic play_row(stim_row_t row);
    repeat (row.reps) send_word(row.req, row.wbyte, row.line, row.fixed, row.want);
  endtask

  task automatic drain_bus();
    while (ph != ST_IDLE) send_word(REQ_TICK, 8'($urandom), 1'($urandom), 1'b0, ST_ZERO);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_timing();
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data <= plan[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      timing[i] = plan[i];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_plan(logic [TW-1:0] v);
    foreach (plan[i]) plan[i] = v;
  endtask

  task automatic run_random(int n);
    req_code_t r;
    repeat (n) begin
      if (ph == ST_IDLE)
        r = ($urandom_range(99) < 85) ? req_code_t'($urandom_range(1, 3)) : REQ_TICK;
      else
        r = ($urandom_range(99) < 5) ? req_code_t'($urandom_range(1, 3)) : REQ_TICK;
      send_word(r, 8'($urandom), 1'($urandom), 1'b0, ST_ZERO);
    end
    drain_bus();
  endtask

  task automatic run_sequence(req_code_t r);
    send_word(r, 8'($urandom), 1'($urandom), 1'b0, ST_ZERO);
    drain_bus();
  endtask

  always @(posedge clk) begin
    bus_status_t want;
    if (!rst && out_valid && out_ready) begin
      if (status_q.size() == 0) begin
        $error("result word with no expectation pending");
        err_count++;
      end else begin
        want = status_q.pop_front();
        check_field("drive_low", want.drive_low, drive_low);
        check_field("busy_res", want.busy_res, busy_res);
        check_field("done_res", want.done_res, done_res);
        check_field("read_byte", want.read_byte, read_byte);
        check_field("presence", want.presence, presence);
      end
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(299) == 0) in_calm <= ~in_calm;
    if ($urandom_range(299) == 0) out_calm <= ~out_calm;
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold = out_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(99) < 30) out_hold = gap_len(out_calm);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_one_wire_bus_master: errors");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < DEFAULT_ROWS; k++) play_row(SCRIPT[k]);
    drain_bus();
    settle();

    fill_plan(10'd1);
    plan[REG_RESET_PRE] = 10'd0;
    plan[REG_PRES_WAIT] = 10'd0;
    plan[REG_WRITE_TAIL] = 10'd0;
    plan[REG_READ_TAIL] = 10'd0;
    apply_timing();
    for (int k = DEFAULT_ROWS; k < SCRIPT_ROWS; k++) play_row(SCRIPT[k]);
    drain_bus();
    settle();

    fill_plan(10'd1);
    apply_timing();
    run_random(130);
    settle();

    repeat (2) begin
      foreach (plan[i]) plan[i] = TW'($urandom_range(12));
      apply_timing();
      run_random(140);
      settle();
    end

    fill_plan(10'd0);
    apply_timing();
    run_sequence(REQ_RESET);
    run_sequence(REQ_WRITE);
    run_sequence(REQ_READ);
    run_random(20);

    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0)
      $display("tb_one_wire_bus_master: clean");
    else
      $display("tb_one_wire_bus_master: errors");
    $finish;
  end

endmodule

/* one_wire_bus_master.f */
design/owbm_pkg.sv
design/owbm_in_reg.sv
design/owbm_seq.sv
design/one_wire_bus_master.sv
design/owbm_checker.sv
bench/tb_one_wire_bus_master.sv
